/* sv/buddy_block_allocator_macros.svh */
// Assertion macros used by the allocator source.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Checked on every clock edge outside reset.
`define BBA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define BBA_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/bba_pkg.sv */
package bba_pkg;

  // Fixed geometry: 1 KiB managed space
  localparam int MEM_LOG2       = 10;
  localparam int ADDR_W         = 10;
  localparam int SIZE_W         = 11;
  localparam int STATUS_W       = 3;
  localparam int DEF_MAX_SPLITS = 5;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd4;

  // Operations of the shared row unit
  typedef enum logic [1:0] {
    OP_CLR_FIRST,
    OP_CLR_BIT,
    OP_SET_BUDDY,
    OP_CLR_RANGE
  } row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [3:0] span;   // log2 of range length for OP_CLR_RANGE
  } row_ctl_t;

  typedef struct packed {
    logic any;          // some block in the row is free
    logic hit;          // block at idx is free
  } row_stat_t;

  // Smallest c with 2^c >= v (0 for v of 0 or 1)
  function automatic logic [3:0] ceil_log2_size(input logic [SIZE_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v > (SIZE_W'(1) << i)) r = 4'(i + 1);
    end
    return r;
  endfunction

  // Position of the highest set bit
  function automatic logic [3:0] floor_log2_size(input logic [SIZE_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

/* sv/bba_ram.sv */
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* sv/bba_row_unit.sv */
module bba_row_unit #(
  parameter int ROW_W = 32,
  parameter int IDX_W = 5
) (
  input  logic [ROW_W-1:0]   row_in,
  input  logic [IDX_W-1:0]   idx,
  input  bba_pkg::row_ctl_t  ctl,
  output logic [ROW_W-1:0]   row_out,
  output bba_pkg::row_stat_t stat,
  output logic [IDX_W-1:0]   first
);

  import bba_pkg::*;

  always_comb begin
    logic [IDX_W-1:0] tgt;
    logic [IDX_W-1:0] bit_i;

    // Lowest free block in the row
    first = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (row_in[i]) first = IDX_W'(i);
    end

    // Flags
    stat.any = |row_in;
    stat.hit = 1'b0;
    for (int i = 0; i < ROW_W; i++) begin
      if (IDX_W'(i) == idx) stat.hit = row_in[i];
    end

    // Target bit of the update
    case (ctl.op)
      OP_CLR_FIRST: tgt = first;
      OP_SET_BUDDY: tgt = idx ^ IDX_W'(1);
      default:      tgt = idx;
    endcase

    // Row update
    row_out = row_in;
    for (int i = 0; i < ROW_W; i++) begin
      bit_i = IDX_W'(i);
      case (ctl.op)
        OP_CLR_FIRST, OP_CLR_BIT: begin
          if (bit_i == tgt) row_out[i] = 1'b0;
        end
        OP_SET_BUDDY: begin
          if (bit_i == tgt) row_out[i] = 1'b1;
        end
        OP_CLR_RANGE: begin
          // idx is aligned to 2^span, so the range is one masked match
          if (((bit_i ^ idx) >> ctl.span) == '0) row_out[i] = 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/buddy_block_allocator.sv */
// Buddy allocator over a 1 KiB space, split down to a minimum block of
// 1024 >> S bytes (S = min(MAX_SPLITS, 10)). Each request is one beat on the
// s_ side and yields exactly one result beat on the m_ side. Free flags live
// in a small RAM with one row per tree level, and one row unit does every
// search, bit test and row update, one read-modify-write of one level at a
// time. A request may be turned away at decode; an allocate climbs from the
// level wanted toward the root to find a free block, then splits down, or
// finds none; a free tests the block and the levels above it, then merges
// buddies and clears the rows below. The block takes no new request while
// one is in progress; a finished result sits in the output register until
// taken, while the next request is already accepted. No pass is needed
// after reset.
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
  parameter int MAX_SPLITS = bba_pkg::DEF_MAX_SPLITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size[10:0], block_address[20:11], free_size[31:21]
  input  logic        s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[2:0], granted_address[12:3], granted_size[23:13]
);

  import bba_pkg::*;

  localparam int S      = (MAX_SPLITS < MEM_LOG2) ? MAX_SPLITS : MEM_LOG2;
  localparam int ROW_W  = 1 << S;
  localparam int DEPTH  = S + 1;
  localparam int LVL_W  = (S > 0) ? $clog2(S + 1) : 1;
  localparam int IDX_W  = (S > 0) ? S : 1;
  localparam logic [ADDR_W-1:0] MIN_MASK = ADDR_W'((1 << (MEM_LOG2 - S)) - 1);
  localparam logic [SIZE_W-1:0] MIN_BLK  = SIZE_W'(1 << (MEM_LOG2 - S));
  localparam logic [SIZE_W-1:0] MEM_BYTES = SIZE_W'(1 << MEM_LOG2);

  typedef enum logic [3:0] {
    IDLE, DECODE,
    A_RD, A_CHK, S_RD, S_WR, GRANT,
    F_RD, F_CHK, M_RD, M_CHK, C_RD, C_WR,
    DONE
  } state_t;

  state_t state;

  // Request registers
  logic              cmd;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] blk_addr;
  logic [SIZE_W-1:0] fsz;

  // Walk registers
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  want;
  logic [LVL_W-1:0]  lvl_keep;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  apos;
  logic [IDX_W-1:0]  clr_lo;
  logic [3:0]        span;
  logic [DEPTH-1:0]  row_ok;

  // Result registers
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [SIZE_W-1:0]   res_size;

  // Row RAM and row unit hookup
  logic              ram_we, ram_re;
  logic [ROW_W-1:0]  ram_rd, row_eff, row_new;
  logic              rd_ok;
  logic [LVL_W-1:0]  rd_lvl;
  logic [IDX_W-1:0]  unit_idx, unit_first;
  row_ctl_t          ctl;
  row_stat_t         stat;

  // Decode results
  logic              dec_oom;
  logic [LVL_W-1:0]  dec_want;
  logic [STATUS_W-1:0] dec_fstat;
  logic [LVL_W-1:0]  dec_flvl;
  logic [IDX_W-1:0]  dec_fpos;

  assign s_tready = (state == IDLE);

  bba_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lvl),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (lvl),
    .rdata (ram_rd)
  );

  // Rows never written read as their reset value: only the root is free
  assign row_eff = rd_ok ? ram_rd : ((rd_lvl == '0) ? ROW_W'(1) : '0);

  bba_row_unit #(.ROW_W(ROW_W), .IDX_W(IDX_W)) u_unit (
    .row_in  (row_eff),
    .idx     (unit_idx),
    .ctl     (ctl),
    .row_out (row_new),
    .stat    (stat),
    .first   (unit_first)
  );

  // Request decode: level wanted by an allocate, operand checks of a free
  always_comb begin
    logic [3:0] c4, w4, fl4;
    c4       = ceil_log2_size(req_size);
    w4       = 4'(MEM_LOG2) - c4;
    dec_oom  = (req_size > MEM_BYTES);
    dec_want = (w4 > 4'(S)) ? LVL_W'(S) : LVL_W'(w4);

    fl4       = 4'(MEM_LOG2) - floor_log2_size(fsz);
    dec_flvl  = LVL_W'(fl4);
    dec_fpos  = IDX_W'(blk_addr >> (4'(MEM_LOG2) - fl4));
    if ((blk_addr & MIN_MASK) != '0) begin
      dec_fstat = ST_BAD_ADDR;
    end else if (fsz == '0 || (fsz & (fsz - SIZE_W'(1))) != '0 ||
                 fsz > MEM_BYTES || fsz < MIN_BLK) begin
      dec_fstat = ST_BAD_SIZE;
    end else if ((blk_addr & ADDR_W'(fsz - SIZE_W'(1))) != '0) begin
      dec_fstat = ST_BAD_ADDR;
    end else begin
      dec_fstat = ST_OK;
    end
  end

  // Row unit control and RAM strobes
  always_comb begin
    ctl.op   = OP_CLR_BIT;
    ctl.span = '0;
    unit_idx = pos;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    case (state)
      A_RD, S_RD, F_RD, M_RD, C_RD: ram_re = 1'b1;
      A_CHK: begin
        ctl.op = OP_CLR_FIRST;
        ram_we = stat.any;
      end
      S_WR: begin
        ctl.op = OP_SET_BUDDY;
        ram_we = 1'b1;
      end
      F_CHK: unit_idx = apos;
      M_CHK: begin
        // test the buddy; clear it to merge, else set this block
        unit_idx = pos ^ IDX_W'(1);
        ctl.op   = (lvl != '0 && stat.hit) ? OP_CLR_BIT : OP_SET_BUDDY;
        ram_we   = 1'b1;
      end
      C_WR: begin
        ctl.op   = OP_CLR_RANGE;
        ctl.span = span;
        unit_idx = clr_lo;
        ram_we   = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      row_ok   <= '0;
      lvl      <= '0;
    end else begin
      if (ram_re) begin
        rd_ok  <= row_ok[lvl];
        rd_lvl <= lvl;
      end
      if (ram_we) row_ok[lvl] <= 1'b1;

      // Output register: loaded from DONE, cleared once taken
      if (state == DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd      <= s_tuser;
            req_size <= s_tdata[10:0];
            blk_addr <= s_tdata[20:11];
            fsz      <= s_tdata[31:21];
            state    <= DECODE;
          end
        end
        DECODE: begin
          res_addr <= '0;
          res_size <= '0;
          if (cmd == CMD_ALLOC) begin
            if (dec_oom) begin
              res_status <= ST_OOM;
              state      <= DONE;
            end else begin
              lvl   <= dec_want;
              want  <= dec_want;
              state <= A_RD;
            end
          end else begin
            if (dec_fstat != ST_OK) begin
              res_status <= dec_fstat;
              state      <= DONE;
            end else begin
              lvl      <= dec_flvl;
              lvl_keep <= dec_flvl;
              pos      <= dec_fpos;
              apos     <= dec_fpos;
              state    <= F_RD;
            end
          end
        end
        A_RD: state <= A_CHK;
        A_CHK: begin
          if (stat.any) begin
            if (lvl == want) begin
              pos   <= unit_first;
              state <= GRANT;
            end else begin
              pos   <= unit_first << 1;
              lvl   <= lvl + LVL_W'(1);
              state <= S_RD;
            end
          end else if (lvl == '0) begin
            res_status <= ST_OOM;
            state      <= DONE;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= A_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (lvl == want) begin
            state <= GRANT;
          end else begin
            pos   <= pos << 1;
            lvl   <= lvl + LVL_W'(1);
            state <= S_RD;
          end
        end
        GRANT: begin
          res_status <= ST_OK;
          res_addr   <= ADDR_W'(ADDR_W'(pos) << (4'(MEM_LOG2) - 4'(want)));
          res_size   <= MEM_BYTES >> want;
          state      <= DONE;
        end
        F_RD: state <= F_CHK;
        F_CHK: begin
          if (stat.hit) begin
            res_status <= ST_ALREADY;
            state      <= DONE;
          end else if (lvl == '0) begin
            lvl   <= lvl_keep;
            state <= M_RD;
          end else begin
            apos  <= apos >> 1;
            lvl   <= lvl - LVL_W'(1);
            state <= F_RD;
          end
        end
        M_RD: state <= M_CHK;
        M_CHK: begin
          if (lvl != '0 && stat.hit) begin
            pos   <= pos >> 1;
            lvl   <= lvl - LVL_W'(1);
            state <= M_RD;
          end else if (lvl == LVL_W'(S)) begin
            res_status <= ST_OK;
            state      <= DONE;
          end else begin
            clr_lo <= pos << 1;
            span   <= 4'd1;
            lvl    <= lvl + LVL_W'(1);
            state  <= C_RD;
          end
        end
        C_RD: state <= C_WR;
        C_WR: begin
          if (lvl == LVL_W'(S)) begin
            res_status <= ST_OK;
            state      <= DONE;
          end else begin
            clr_lo <= clr_lo << 1;
            span   <= span + 4'd1;
            lvl    <= lvl + LVL_W'(1);
            state  <= C_RD;
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {res_size, res_addr, res_status};
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `BBA_CHECK(a_ram_no_collide, !(ram_we && ram_re), "row read and write in one cycle")
  `BBA_CHECK(a_busy_after_beat, (s_tvalid && s_tready) |=> !s_tready, "ready after accepted beat")
  `BBA_CHECK(a_size_only_on_ok, (m_tvalid && (m_tdata[23:13] != '0)) |-> (m_tdata[2:0] == ST_OK), "size granted on failed request")
  `BBA_CHECK(a_level_in_tree, lvl <= LVL_W'(S), "level beyond tree depth")
  `BBA_CHECK_RST(a_reset_idle, rst |=> (s_tready && !m_tvalid), "not idle after reset")

endmodule
